>>> design/sky_frequency_coincidence_test_macros.svh
// Assertion macros for the coincidence test block.
`ifndef SKY_FREQUENCY_COINCIDENCE_TEST_MACROS_SVH
`define SKY_FREQUENCY_COINCIDENCE_TEST_MACROS_SVH
`ifndef ASSERT_OFF
`define SFC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> design/sfc_pkg.sv
`default_nettype none
package sfc_pkg;
	localparam int INDEX_BITS = 20;
	localparam int FREQ_W = 44;
	localparam int ANG_W = 32;
	localparam int FSTAT_W = 32;
	localparam int MAXANG_W = 30;
	localparam int FA_W = 32;
	localparam int JOINT_W = 64;
	localparam int CFG_W = 44;

	localparam int CW = 34;
	localparam int DW = 2 * CW;
	localparam int CORDIC_STEPS = 30;
	localparam logic signed [CW-1:0] PI_Q28 = 34'sd843314857;
	localparam logic signed [CW-1:0] TWO_PI_Q28 = 34'sd1686629714;
	localparam logic signed [CW-1:0] HALF_PI_Q28 = 34'sd421657428;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [CW-1:0] ONE_Q30 = 34'sd1073741824;
	localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
		30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
		30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
		30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
		30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
		30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002
	};

	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [30:0] LN2_Q31 = 31'd1488522236;
	localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
	localparam logic [15:0] FA_ZERO_EXP = 16'd48;
	localparam int TAYLOR_TERMS = 12;
	localparam int RECIP_SHIFT = 33;

	localparam int ROT_LAT = CORDIC_STEPS + 1;
	localparam int SKY_LAT = ROT_LAT + 4;
	localparam int FA_LAT = 3 * TAYLOR_TERMS + 5;
	localparam int LAT = FA_LAT + 1;

	typedef enum logic [0:0] {
		REG_FREQ_WINDOW = 1'b0,
		REG_MAX_ANGLE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq_first;
		logic signed [ANG_W-1:0] lon_first;
		logic signed [ANG_W-1:0] lat_first;
		logic [FSTAT_W-1:0] fstat_first;
		logic [INDEX_BITS-1:0] index_first;
		logic [FREQ_W-1:0] freq_second;
		logic signed [ANG_W-1:0] lon_second;
		logic signed [ANG_W-1:0] lat_second;
		logic [FSTAT_W-1:0] fstat_second;
		logic [INDEX_BITS-1:0] index_second;
	} pair_t;

	typedef struct packed {
		logic coincident;
		logic [INDEX_BITS-1:0] pair_first;
		logic [INDEX_BITS-1:0] pair_second;
		logic [FA_W-1:0] false_alarm_first;
		logic [FA_W-1:0] false_alarm_second;
		logic [JOINT_W-1:0] joint_false_alarm;
	} result_t;
endpackage
`default_nettype wire

>>> design/sfc_if.sv
`default_nettype none
interface sfc_pair_if;
	logic valid;
	logic ready;
	sfc_pkg::pair_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface sfc_result_if;
	logic valid;
	logic ready;
	sfc_pkg::result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/sfc_rotator.sv
`default_nettype none
module sfc_rotator (
	input  logic clk,
	input  logic en,
	input  logic signed [sfc_pkg::ANG_W-1:0] angle,
	output logic signed [sfc_pkg::CW-1:0] cos_val,
	output logic signed [sfc_pkg::CW-1:0] sin_val
);
	localparam int CW = sfc_pkg::CW;
	localparam int N = sfc_pkg::CORDIC_STEPS;

	logic signed [CW-1:0] wrap;
	logic signed [CW-1:0] fold;
	logic flip;

	logic signed [CW-1:0] x_s [0:N];
	logic signed [CW-1:0] y_s [0:N];
	logic signed [CW-1:0] z_s [0:N];
	logic flip_s [0:N];

	always_comb begin
		wrap = CW'(angle);
		if (wrap > sfc_pkg::PI_Q28) begin
			wrap = wrap - sfc_pkg::TWO_PI_Q28;
		end else if (wrap < -sfc_pkg::PI_Q28) begin
			wrap = wrap + sfc_pkg::TWO_PI_Q28;
		end
		flip = 1'b0;
		fold = wrap;
		if (wrap > sfc_pkg::HALF_PI_Q28) begin
			fold = wrap - sfc_pkg::PI_Q28;
			flip = 1'b1;
		end else if (wrap < -sfc_pkg::HALF_PI_Q28) begin
			fold = wrap + sfc_pkg::PI_Q28;
			flip = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= sfc_pkg::CORDIC_GAIN;
			y_s[0] <= '0;
			z_s[0] <= fold <<< 2;
			flip_s[0] <= flip;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] at;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign at = {{(CW-30){1'b0}}, sfc_pkg::ATAN_Q30[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + at;
				end
				flip_s[i+1] <= flip_s[i];
			end
		end
	end

	assign cos_val = flip_s[N] ? -x_s[N] : x_s[N];
	assign sin_val = flip_s[N] ? -y_s[N] : y_s[N];
endmodule
`default_nettype wire

>>> design/sfc_sky.sv
`default_nettype none
module sfc_sky (
	input  logic clk,
	input  logic en,
	input  logic signed [sfc_pkg::ANG_W-1:0] lon_first,
	input  logic signed [sfc_pkg::ANG_W-1:0] lat_first,
	input  logic signed [sfc_pkg::ANG_W-1:0] lon_second,
	input  logic signed [sfc_pkg::ANG_W-1:0] lat_second,
	input  logic [sfc_pkg::MAXANG_W-1:0] max_angle,
	output logic sky_ok
);
	localparam int CW = sfc_pkg::CW;
	localparam int DW = sfc_pkg::DW;

	logic signed [sfc_pkg::ANG_W-1:0] lim;
	logic signed [CW-1:0] ca1, sa1, cd1, sd1, ca2, sa2, cd2, sd2, cmax, smax;
	logic signed [DW-1:0] p_x1, p_y1, p_x2, p_y2;
	logic signed [CW-1:0] nx1_s32, ny1_s32, nz1_s32, nx2_s32, ny2_s32, nz2_s32, cmax_s32;
	logic signed [DW-1:0] dx_s33, dy_s33, dz_s33;
	logic signed [CW-1:0] cmax_s33, dot_s34, cmax_s34;
	logic signed [DW-1:0] dsum, dsh;
	logic signed [CW-1:0] dot_c;
	logic sky_ok_s35;

	assign lim = (max_angle > sfc_pkg::MAXANG_W'(sfc_pkg::PI_Q28)) ?
		sfc_pkg::ANG_W'(sfc_pkg::PI_Q28) : sfc_pkg::ANG_W'({2'b00, max_angle});

	sfc_rotator u_lon1 (.clk(clk), .en(en), .angle(lon_first), .cos_val(ca1), .sin_val(sa1));
	sfc_rotator u_lat1 (.clk(clk), .en(en), .angle(lat_first), .cos_val(cd1), .sin_val(sd1));
	sfc_rotator u_lon2 (.clk(clk), .en(en), .angle(lon_second), .cos_val(ca2), .sin_val(sa2));
	sfc_rotator u_lat2 (.clk(clk), .en(en), .angle(lat_second), .cos_val(cd2), .sin_val(sd2));
	sfc_rotator u_lim (.clk(clk), .en(en), .angle(lim), .cos_val(cmax), .sin_val(smax));

	assign p_x1 = ca1 * cd1;
	assign p_y1 = sa1 * cd1;
	assign p_x2 = ca2 * cd2;
	assign p_y2 = sa2 * cd2;

	always_comb begin
		dsum = dx_s33 + dy_s33 + dz_s33;
		dsh = dsum >>> 30;
		if (dsh > DW'(sfc_pkg::ONE_Q30)) begin
			dot_c = sfc_pkg::ONE_Q30;
		end else if (dsh < -DW'(sfc_pkg::ONE_Q30)) begin
			dot_c = -sfc_pkg::ONE_Q30;
		end else begin
			dot_c = CW'(dsh);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx1_s32 <= CW'(p_x1 >>> 30);
			ny1_s32 <= CW'(p_y1 >>> 30);
			nz1_s32 <= sd1;
			nx2_s32 <= CW'(p_x2 >>> 30);
			ny2_s32 <= CW'(p_y2 >>> 30);
			nz2_s32 <= sd2;
			cmax_s32 <= cmax;
			dx_s33 <= nx1_s32 * nx2_s32;
			dy_s33 <= ny1_s32 * ny2_s32;
			dz_s33 <= nz1_s32 * nz2_s32;
			cmax_s33 <= cmax_s32;
			dot_s34 <= dot_c;
			cmax_s34 <= cmax_s33;
			sky_ok_s35 <= (dot_s34 >= cmax_s34) && (smax == smax);
		end
	end

	assign sky_ok = sky_ok_s35;
endmodule
`default_nettype wire

>>> design/sfc_false_alarm.sv
`default_nettype none
module sfc_false_alarm (
	input  logic clk,
	input  logic en,
	input  logic [sfc_pkg::FSTAT_W-1:0] fstat,
	output logic [sfc_pkg::FA_W:0] fa
);
	localparam int T = sfc_pkg::TAYLOR_TERMS;
	localparam int RS = sfc_pkg::RECIP_SHIFT;
	localparam bit LAST_SUB = (T % 2) == 1;

	typedef struct packed {
		logic [31:0] f;
		logic [30:0] r;
		logic zero;
		logic [5:0] sh;
	} fa_side_t;

	logic [62:0] t_s1;
	logic [31:0] f_s1;
	logic [61:0] rp;
	fa_side_t side_s2;

	logic [31:0] term_c [1:T];
	logic [31:0] sum_c [1:T];
	fa_side_t side_c [1:T];

	logic [31:0] sum_s39;
	fa_side_t side_s39;
	logic [64:0] pw;
	logic [63:0] prod_s40;
	logic zero_s40;
	logic [5:0] sh_s40;
	logic [63:0] v;
	logic [6:0] shamt;
	logic [32:0] fa_s41;

	assign rp = t_s1[46:16] * sfc_pkg::LN2_Q31;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= fstat * sfc_pkg::LOG2E_Q30;
			f_s1 <= fstat;
			side_s2.f <= f_s1;
			side_s2.r <= rp[61:31];
			side_s2.zero <= t_s1[62:47] >= sfc_pkg::FA_ZERO_EXP;
			side_s2.sh <= t_s1[52:47];
		end
	end

	for (genvar k = 1; k <= T; k++) begin : g_term
		localparam logic [RS-1:0] RECIP = RS'(((65'd1 << RS) - 65'd1) / k);
		localparam logic [3:0] K = 4'(k);
		localparam bit SUB = ((k - 1) % 2) == 1;
		logic [31:0] term_in, sum_in, sum_nx;
		fa_side_t side_in;
		logic [62:0] tr;
		logic [31:0] mt_sa, sum_sa, mt_sb, q0_sb, sum_sb, rem;
		fa_side_t side_sa, side_sb;
		logic [64:0] qm;
		logic [35:0] kq;
		if (k == 1) begin : g_first
			assign term_in = sfc_pkg::ONE_Q31;
			assign sum_in = sfc_pkg::ONE_Q31;
			assign side_in = side_s2;
			assign sum_nx = sum_in ^ (term_in & 32'h0);
		end else begin : g_next
			assign term_in = term_c[k-1];
			assign sum_in = sum_c[k-1];
			assign side_in = side_c[k-1];
			assign sum_nx = SUB ? sum_in - term_in : sum_in + term_in;
		end
		assign tr = term_in * side_in.r;
		assign qm = mt_sa * RECIP;
		assign kq = q0_sb * K;
		assign rem = mt_sb - kq[31:0];
		always_ff @(posedge clk) begin
			if (en) begin
				mt_sa <= tr[62:31];
				sum_sa <= sum_nx;
				side_sa <= side_in;
				mt_sb <= mt_sa;
				q0_sb <= qm[64:RS];
				sum_sb <= sum_sa;
				side_sb <= side_sa;
				term_c[k] <= (rem >= 32'(K)) ? q0_sb + 32'd1 : q0_sb;
				sum_c[k] <= sum_sb;
				side_c[k] <= side_sb;
			end
		end
	end

	assign pw = ({1'b0, side_s39.f} + 33'h2_0000) * sum_s39;
	assign shamt = 7'd16 + 7'(sh_s40);
	assign v = prod_s40 >> shamt;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s39 <= LAST_SUB ? sum_c[T] - term_c[T] : sum_c[T] + term_c[T];
			side_s39 <= side_c[T];
			prod_s40 <= pw[63:0];
			zero_s40 <= side_s39.zero;
			sh_s40 <= side_s39.sh;
			if (zero_s40) begin
				fa_s41 <= '0;
			end else if (v > 64'h1_0000_0000) begin
				fa_s41 <= 33'h1_0000_0000;
			end else begin
				fa_s41 <= v[32:0];
			end
		end
	end

	assign fa = fa_s41;
endmodule
`default_nettype wire

>>> design/sky_frequency_coincidence_test.sv
// Sky and frequency coincidence test for candidate pairs.
// Channel pair (sink): one request per pair of candidates, taken at a clock
// edge with valid and ready high. Channel result (source): one result per
// request, in request order, same valid/ready rule.
// Configuration: cfg_we, cfg_index and cfg_data write freq_window (index 0)
// or max_angular_distance (index 1); write only while no request is in flight.
// One request is taken every cycle while the pipeline is not held. The depth
// is set by the false alarm unit: two setup stages, three stages for each of
// the 12 terms of the exponential series, three stages to scale and cap, and
// the result register. The 30-step CORDIC sky path takes 35 stages and is
// delayed to match.
// While a result waits unaccepted the whole pipeline holds as it is; ready on
// the pair channel then stays low until the result is taken. While no result
// waits, the pipeline advances whatever the state of ready.
// Reset (arst_n low) clears the configuration and valid registers and empties the pipeline.
`default_nettype none
`include "sky_frequency_coincidence_test_macros.svh"
module sky_frequency_coincidence_test (
	input  logic clk,
	input  logic arst_n,
	sfc_pair_if.sink pair,
	sfc_result_if.source result,
	input  logic cfg_we,
	input  sfc_pkg::cfg_reg_t cfg_index,
	input  logic [sfc_pkg::CFG_W-1:0] cfg_data
);
	localparam int LAT = sfc_pkg::LAT;
	localparam int SL = sfc_pkg::SKY_LAT;
	localparam int IB = sfc_pkg::INDEX_BITS;

	logic [sfc_pkg::FREQ_W-1:0] freq_window_q;
	logic [sfc_pkg::MAXANG_W-1:0] max_angle_q;
	logic en, take;
	logic vld_s [1:LAT];
	logic freq_ok_s [1:LAT-1];
	logic sky_ok_s [SL+1:LAT-1];
	logic [IB-1:0] idx1_s [1:LAT-1];
	logic [IB-1:0] idx2_s [1:LAT-1];
	logic [sfc_pkg::FREQ_W-1:0] diff;
	logic sky_ok;
	logic [sfc_pkg::FA_W:0] fa1, fa2;
	logic [63:0] joint_c;
	logic [63:0] prod_c;
	sfc_pkg::result_t res_s42;

	assign en = !vld_s[LAT] || result.ready;
	assign take = pair.valid && en;
	assign pair.ready = en;
	assign result.valid = vld_s[LAT];
	assign result.data = res_s42;

	assign diff = (pair.data.freq_first > pair.data.freq_second) ?
		pair.data.freq_first - pair.data.freq_second :
		pair.data.freq_second - pair.data.freq_first;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_window_q <= '0;
			max_angle_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sfc_pkg::REG_FREQ_WINDOW: freq_window_q <= cfg_data;
				sfc_pkg::REG_MAX_ANGLE: max_angle_q <= cfg_data[sfc_pkg::MAXANG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= take;
			for (int i = 2; i <= LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	sfc_sky u_sky (
		.clk(clk), .en(en),
		.lon_first(pair.data.lon_first), .lat_first(pair.data.lat_first),
		.lon_second(pair.data.lon_second), .lat_second(pair.data.lat_second),
		.max_angle(max_angle_q), .sky_ok(sky_ok)
	);

	sfc_false_alarm u_fa1 (.clk(clk), .en(en), .fstat(pair.data.fstat_first), .fa(fa1));
	sfc_false_alarm u_fa2 (.clk(clk), .en(en), .fstat(pair.data.fstat_second), .fa(fa2));

	assign prod_c = fa1[31:0] * fa2[31:0];

	always_comb begin
		if (fa1[32] && fa2[32]) begin
			joint_c = '1;
		end else if (fa1[32]) begin
			joint_c = {fa2[31:0], 32'h0};
		end else if (fa2[32]) begin
			joint_c = {fa1[31:0], 32'h0};
		end else begin
			joint_c = prod_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			freq_ok_s[1] <= diff <= freq_window_q;
			idx1_s[1] <= pair.data.index_first;
			idx2_s[1] <= pair.data.index_second;
			for (int i = 2; i <= LAT - 1; i++) begin
				freq_ok_s[i] <= freq_ok_s[i-1];
				idx1_s[i] <= idx1_s[i-1];
				idx2_s[i] <= idx2_s[i-1];
			end
			sky_ok_s[SL+1] <= sky_ok;
			for (int i = SL + 2; i <= LAT - 1; i++) sky_ok_s[i] <= sky_ok_s[i-1];
			res_s42.coincident <= freq_ok_s[LAT-1] && sky_ok_s[LAT-1];
			res_s42.pair_first <= idx1_s[LAT-1];
			res_s42.pair_second <= idx2_s[LAT-1];
			res_s42.false_alarm_first <= fa1[32] ? '1 : fa1[31:0];
			res_s42.false_alarm_second <= fa2[32] ? '1 : fa2[31:0];
			res_s42.joint_false_alarm <= joint_c;
		end
	end

	`SFC_ASSERT(a_advance, clk, arst_n, en |=> vld_s[2] == $past(vld_s[1]), "valid lost in advance")
	`SFC_ASSERT(a_hold, clk, arst_n, !en |=> vld_s[1] == $past(vld_s[1]), "valid moved in stall")
	`SFC_ASSERT_ALWAYS(a_reset, clk, !arst_n |-> !result.valid, "result valid in reset")
endmodule
`default_nettype wire
